>>> hdl/qbp_pkg.sv
// Shared types and constants for the quietest band picker.
`default_nettype none

package qbp_pkg;

    localparam int NUM_KEEP = 3;

    typedef logic [7:0]  index_t;
    typedef logic [15:0] value_t;
    typedef logic [11:0] freq_t;

    // Register selects, decoded from paddr[2]
    localparam logic REG_START_FREQ = 1'b0;
    localparam logic REG_FREQ_STEP  = 1'b1;

    localparam logic [8:0] START_FREQ_RESET = 9'd4;
    localparam logic [3:0] FREQ_STEP_RESET  = 4'd1;
    localparam freq_t      FREQ_MAX         = 12'hFFF;

    typedef struct packed {
        logic [15:0] sample;
        logic        last_sample;
    } qbp_in_t;

    typedef struct packed {
        logic [1:0]  rank;
        logic [7:0]  band_index;
        logic [15:0] band_value;
        logic [11:0] band_frequency;
        logic        last_result;
    } qbp_out_t;

    typedef struct packed {
        value_t value;
        index_t index;
    } qbp_entry_t;

    localparam qbp_entry_t ENTRY_EMPTY = '{value: 16'hFFFF, index: 8'd0};

    // Kept bands in ascending order, with the number of valid entries
    typedef struct packed {
        qbp_entry_t [NUM_KEEP-1:0] entry;
        logic [1:0]                count;
    } qbp_list_t;

endpackage

`default_nettype wire

>>> hdl/qbp_top3.sv
// Running stable top-three minimum list of one scan run.
`default_nettype none

module qbp_top3 #(
    parameter int MAX_BANDS = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire qbp_pkg::qbp_in_t   beat,
    output qbp_pkg::qbp_list_t      list
);

    localparam int CNT_W = $clog2(MAX_BANDS + 1);

    qbp_pkg::qbp_entry_t [qbp_pkg::NUM_KEEP-1:0] best_reg;
    logic [1:0]       count_reg;
    logic [CNT_W-1:0] band_counter_reg;

    logic                in_range;
    logic [2:0]          lt;
    logic [1:0]          pos;
    qbp_pkg::qbp_entry_t item;

    assign in_range   = band_counter_reg < CNT_W'(MAX_BANDS);
    assign item.value = beat.sample;
    assign item.index = qbp_pkg::index_t'(band_counter_reg);

    always_comb
    begin
        for (int k = 0; k < qbp_pkg::NUM_KEEP; k++)
        begin
            lt[k] = (2'(k) < count_reg) && (beat.sample < best_reg[k].value);
        end
    end

    // First kept entry that is strictly larger; equal samples stay ahead
    always_comb
    begin
        priority if (lt[0])
            pos = 2'd0;
        else if (lt[1])
            pos = 2'd1;
        else if (lt[2])
            pos = 2'd2;
        else
            pos = count_reg;
    end

    // List including this beat; drop the sample when it lands past rank two
    always_comb
    begin
        list.entry = best_reg;
        list.count = count_reg;
        if (in_range && pos != 2'd3)
        begin
            unique case (pos)
                2'd0:
                begin
                    list.entry[0] = item;
                    list.entry[1] = best_reg[0];
                    list.entry[2] = best_reg[1];
                end
                2'd1:
                begin
                    list.entry[1] = item;
                    list.entry[2] = best_reg[1];
                end
                default:
                begin
                    list.entry[2] = item;
                end
            endcase
            if (count_reg != 2'd3)
                list.count = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg         <= {qbp_pkg::NUM_KEEP{qbp_pkg::ENTRY_EMPTY}};
            count_reg        <= 2'd0;
            band_counter_reg <= '0;
        end
        else if (accept)
        begin
            if (beat.last_sample)
            begin
                best_reg         <= {qbp_pkg::NUM_KEEP{qbp_pkg::ENTRY_EMPTY}};
                count_reg        <= 2'd0;
                band_counter_reg <= '0;
            end
            else
            begin
                best_reg  <= list.entry;
                count_reg <= list.count;
                if (in_range)
                    band_counter_reg <= band_counter_reg + CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/quietest_band_picker.sv
// Top level of the quietest band picker: scan input, result drain, register port.
// Latency: results of a run appear the cycle after its last band beat, one per cycle while result_stall is low.
// Throughput: one band beat per cycle; a last beat stalls while results of the previous
// run are still waiting, unless the final one is taken in that same cycle (one run drains).
// A run of N bands yields min(N,3) results, ranks 0..2 in ascending sample order.
// Reset (rst_n low, async) clears the run state and drain and loads register defaults.
`default_nettype none

module quietest_band_picker #(
    parameter int MAX_BANDS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    // Band beats of the scan run
    input  wire logic              band_valid,
    output logic                   band_stall,
    input  wire qbp_pkg::qbp_in_t  band_data,

    // Ranked result beats
    output logic                   result_valid,
    input  wire logic              result_stall,
    output qbp_pkg::qbp_out_t      result_data,

    // Register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [8:0] start_freq_reg;
    logic [3:0] freq_step_reg;

    // Drain buffer: snapshot of the finished run, remaining count and next rank
    qbp_pkg::qbp_list_t snap_reg;
    logic [1:0]         left_reg;
    logic [1:0]         rank_reg;

    logic               band_accept;
    logic               result_accept;
    logic               snap_free;
    logic               capture;
    qbp_pkg::qbp_list_t run_list;
    qbp_pkg::qbp_entry_t cur;
    logic [12:0]        freq_sum;

    // ------------------------------------------------------------------
    // Register port: write on the access phase, reads are combinational
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_freq_reg <= qbp_pkg::START_FREQ_RESET;
            freq_step_reg  <= qbp_pkg::FREQ_STEP_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                qbp_pkg::REG_START_FREQ: start_freq_reg <= pwdata[8:0];
                qbp_pkg::REG_FREQ_STEP:  freq_step_reg  <= pwdata[3:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            qbp_pkg::REG_START_FREQ: prdata = {23'd0, start_freq_reg};
            qbp_pkg::REG_FREQ_STEP:  prdata = {28'd0, freq_step_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes. Ordinary band beats always flow; a last beat needs the
    // drain to be empty, or to be handing out its final result right now.
    // ------------------------------------------------------------------
    assign result_valid  = left_reg != 2'd0;
    assign result_accept = result_valid && !result_stall;
    assign snap_free     = (left_reg == 2'd0) || (left_reg == 2'd1 && result_accept);
    assign band_stall    = band_data.last_sample && !snap_free;
    assign band_accept   = band_valid && !band_stall;
    assign capture       = band_accept && band_data.last_sample;

    qbp_top3 #(
        .MAX_BANDS (MAX_BANDS)
    ) u_top3 (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (band_accept),
        .beat   (band_data),
        .list   (run_list)
    );

    // ------------------------------------------------------------------
    // Drain: hold the finished list, advance one rank per result beat
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
            rank_reg <= 2'd0;
        end
        else if (capture)
        begin
            left_reg <= run_list.count;
            rank_reg <= 2'd0;
        end
        else if (result_accept)
        begin
            left_reg <= left_reg - 2'd1;
            rank_reg <= rank_reg + 2'd1;
        end
    end

    // Payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (capture)
            snap_reg <= run_list;
    end

    // Frequency code of the band on offer, saturated to 12 bits
    assign cur      = snap_reg.entry[rank_reg];
    assign freq_sum = {4'd0, start_freq_reg} + 13'(freq_step_reg) * 13'(cur.index);

    always_comb
    begin
        result_data.rank        = rank_reg;
        result_data.band_index  = cur.index;
        result_data.band_value  = cur.value;
        result_data.band_frequency = (freq_sum > 13'(qbp_pkg::FREQ_MAX))
                                     ? qbp_pkg::FREQ_MAX : freq_sum[11:0];
        result_data.last_result = left_reg == 2'd1;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // A run is never captured over results that are still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        capture |-> snap_free)
        else $error("run captured over pending results");

    // A stalled band beat means results are still pending
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        band_stall |-> result_valid)
        else $error("band stalled with empty drain");

    // Ranks of one run follow each other without a gap
    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_accept && !result_data.last_result) |=>
            (result_valid && result_data.rank == $past(result_data.rank) + 2'd1))
        else $error("rank sequence broken");

    // Values of one run come out in ascending order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_accept && !result_data.last_result) |=>
            (result_data.band_value >= $past(result_data.band_value)))
        else $error("results not in ascending order");

endmodule

`default_nettype wire
